@@ rtl/mlp_pkg.sv @@
// Package: types, constants and sigmoid table of the perceptron inference unit.
package mlp_pkg;

  localparam int MaxInputs = 4;
  localparam int MaxHidden = 4;
  localparam int NumW      = MaxInputs * MaxHidden;
  localparam int IdxHb     = NumW;
  localparam int IdxOw     = NumW + MaxHidden;
  localparam int IdxOb     = NumW + 2 * MaxHidden;
  localparam int AccW      = 44;
  localparam int HidW      = $clog2(MaxHidden);
  localparam int CntW      = $clog2(MaxInputs + 1);
  localparam int ParW      = $clog2(NumW);

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  param_index;
    logic signed [15:0] param_value;
    logic signed [23:0] sample_value;
    logic        last_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0] prediction;
    logic        too_many_inputs;
  } out_word_t;

  function automatic logic [15:0] sig_tab(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0: v = 16'd22;     6'd1: v = 16'd36;     6'd2: v = 16'd60;
      6'd3: v = 16'd98;     6'd4: v = 16'd162;    6'd5: v = 16'd267;
      6'd6: v = 16'd439;    6'd7: v = 16'd720;    6'd8: v = 16'd1179;
      6'd9: v = 16'd1921;   6'd10: v = 16'd3108;  6'd11: v = 16'd4971;
      6'd12: v = 16'd7812;  6'd13: v = 16'd11955; 6'd14: v = 16'd17625;
      6'd15: v = 16'd24743; 6'd16: v = 16'd32768; 6'd17: v = 16'd40793;
      6'd18: v = 16'd47911; 6'd19: v = 16'd53581; 6'd20: v = 16'd57724;
      6'd21: v = 16'd60565; 6'd22: v = 16'd62428; 6'd23: v = 16'd63615;
      6'd24: v = 16'd64357; 6'd25: v = 16'd64816; 6'd26: v = 16'd65097;
      6'd27: v = 16'd65269; 6'd28: v = 16'd65374; 6'd29: v = 16'd65438;
      6'd30: v = 16'd65476; 6'd31: v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/mlp_if.sv @@
// Interfaces: valid/ready channels for input and result words.
interface mlp_in_if;
  logic valid;
  logic ready;
  mlp_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlp_out_if;
  logic valid;
  logic ready;
  mlp_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mlp_one_hidden_layer_inference_unit.sv @@
// Top level: one-hidden-layer perceptron forward pass with sigmoid output.
//
//  channel   dir  handshake          contents
//  in_if     in   valid/ready        opcode, param_index, param_value, sample_value, last_sample
//  out_if    out  valid/ready        prediction, too_many_inputs
//  cfg       in   cfg_we_i           hidden_in_use (3 bits)
//
// A parameter write is taken in the idle state, as is a sample past the input limit
// that is not a last sample. A sample walks the hidden accumulators, which live in one
// memory whose single read/write port takes all MaxHidden neurons in turn through SMacRd,
// SMacMul, SHAdd and SMacWr. A last sample then runs the states from SHRd to SOIx for each
// hidden neuron in use, and SOSat, SORd, SHMul, SHAcc and SOOut for the output sigmoid.
// Reset clears control state and the accumulators (valid bits); parameter
// memories are left undefined. A stalled result holds in the output register
// while the next word may already be accepted, unless that word is a last
// sample, which waits until the result has been taken.
module mlp_one_hidden_layer_inference_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  mlp_in_if.sink     in_if,
  mlp_out_if.source  out_if
);
  import mlp_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SMacRd = 4'd1, SMacMul = 4'd2, SMacWr = 4'd3,
                         SHRd = 4'd4, SHAdd = 4'd5, SHSat = 4'd6, SHIx = 4'd7,
                         SHMul = 4'd8, SHAcc = 4'd9, SOSat = 4'd10, SOIx = 4'd11,
                         SOMul = 4'd12, SOOut = 4'd13, SORd = 4'd14;

  // Parameter memories (one synchronous read port each).
  logic signed [15:0] wmem [NumW];
  logic signed [15:0] hbmem [MaxHidden];
  logic signed [15:0] owmem [MaxHidden];
  logic signed [15:0] ob_q;
  logic signed [AccW-1:0] accmem [MaxHidden];
  logic [MaxHidden-1:0] accv_q;

  logic [3:0] st_q;
  logic [2:0] hiu_q;
  logic [HidW-1:0] h_q;
  logic [CntW-1:0] cnt_q;
  logic ovf_q, last_q;
  logic signed [23:0] sv_q;
  logic signed [15:0] w_rd_q, hb_rd_q, ow_rd_q;
  logic signed [AccW-1:0] acc_rd_q;
  logic signed [AccW-1:0] acc_raw;
  logic signed [39:0] prod_q;
  logic signed [AccW+1:0] sum_q;
  logic signed [AccW+1:0] x_q;
  logic [32:0] u_q;
  logic signed [47:0] osum_q;
  logic signed [33:0] oprod_q;
  logic [16:0] a_q;
  logic [15:0] t0_q;
  logic [16:0] dt_q;
  logic [27:0] fr_q;
  logic [44:0] ip_q;
  logic [5:0] ix_q;
  logic osel_q;
  logic out_v_q;
  out_word_t out_q;
  logic [2:0] nh;
  logic [HidW-1:0] hlast;

  always_comb begin
    if (hiu_q == 3'd0) nh = 3'd1;
    else if (32'(hiu_q) > MaxHidden) nh = 3'(MaxHidden);
    else nh = hiu_q;
    hlast = HidW'(nh - 3'd1);
  end

  assign acc_raw = accv_q[h_q] ? acc_rd_q : '0;
  assign in_if.ready = (st_q == SIdle) && !(out_v_q && in_if.data.opcode == OpSample
                        && in_if.data.last_sample && !out_if.ready);
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  wire acc_in = in_if.valid && in_if.ready;

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (acc_in && in_if.data.opcode == OpWrite) begin
      if (32'(in_if.data.param_index) < IdxHb)
        wmem[in_if.data.param_index[ParW-1:0]] <= in_if.data.param_value;
      else if (32'(in_if.data.param_index) < IdxOw)
        hbmem[HidW'(in_if.data.param_index - 5'(IdxHb))] <= in_if.data.param_value;
      else if (32'(in_if.data.param_index) < IdxOb)
        owmem[HidW'(in_if.data.param_index - 5'(IdxOw))] <= in_if.data.param_value;
      else if (32'(in_if.data.param_index) == IdxOb)
        ob_q <= in_if.data.param_value;
    end
    w_rd_q   <= wmem[ParW'(32'(cnt_q) * MaxHidden + 32'(h_q))];
    hb_rd_q  <= hbmem[h_q];
    ow_rd_q  <= owmem[h_q];
    acc_rd_q <= accmem[h_q];
    if (st_q == SMacWr) begin
      if (sum_q > $signed((AccW+2)'({1'b0, {(AccW-1){1'b1}}})))
        accmem[h_q] <= {1'b0, {(AccW-1){1'b1}}};
      else if (sum_q < -$signed((AccW+2)'({1'b0, {(AccW-1){1'b1}}})) - 1)
        accmem[h_q] <= {1'b1, {(AccW-1){1'b0}}};
      else accmem[h_q] <= sum_q[AccW-1:0];
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; hiu_q <= 3'd3; h_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      last_q <= 1'b0; accv_q <= '0; out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) hiu_q <= cfg_wdata_i;
      if (out_v_q && out_if.ready && st_q != SOOut) out_v_q <= 1'b0;
      case (st_q)
        SIdle: begin
          if (acc_in && in_if.data.opcode == OpSample) begin
            sv_q <= in_if.data.sample_value;
            last_q <= in_if.data.last_sample;
            h_q <= '0;
            if (32'(cnt_q) < MaxInputs) st_q <= SMacRd;
            else begin
              ovf_q <= 1'b1;
              st_q <= in_if.data.last_sample ? SHRd : SIdle;
              osum_q <= '0;
            end
          end
        end
        SMacRd:  st_q <= SMacMul;
        SMacMul: begin
          prod_q <= sv_q * w_rd_q;
          st_q <= SHAdd;
          osel_q <= 1'b0;
        end
        SHAdd: begin
          sum_q <= (AccW+2)'(acc_raw) + (AccW+2)'(prod_q);
          st_q <= SMacWr;
        end
        SMacWr: begin
          accv_q[h_q] <= 1'b1;
          if (32'(h_q) == MaxHidden - 1) begin
            h_q <= '0;
            cnt_q <= cnt_q + 1'b1;
            st_q <= last_q ? SHRd : SIdle;
            osum_q <= '0;
          end else begin
            h_q <= h_q + 1'b1;
            st_q <= SMacRd;
          end
        end
        SHRd: st_q <= SHSat;
        SHSat: begin
          // Hidden argument, Q.20, saturated to +-8.
          x_q <= (AccW+2)'(acc_raw) + ((AccW+2)'(hb_rd_q) <<< 8);
          st_q <= SHIx;
        end
        SHIx: begin
          if (x_q > (AccW+2)'(8 <<< 20)) u_q <= 33'(16 << 20);
          else if (x_q < -(AccW+2)'(8 <<< 20)) u_q <= '0;
          else u_q <= 33'(x_q + (AccW+2)'(8 <<< 20));
          osel_q <= 1'b0;
          st_q <= SORd;
        end
        SORd: begin
          // Table lookup: shared by hidden (fb 20) and output (fb 28).
          ix_q <= osel_q ? 6'(u_q >> 27) : 6'(u_q >> 19);
          fr_q <= osel_q ? u_q[26:0] : 28'(u_q[18:0]);
          t0_q <= osel_q ? sig_tab(6'(u_q >> 27)) : sig_tab(6'(u_q >> 19));
          dt_q <= osel_q ? 17'(sig_tab(6'(u_q >> 27) + 6'd1)) - 17'(sig_tab(6'(u_q >> 27)))
                         : 17'(sig_tab(6'(u_q >> 19) + 6'd1)) - 17'(sig_tab(6'(u_q >> 19)));
          st_q <= SHMul;
        end
        SHMul: begin
          ip_q <= 45'(dt_q) * 45'(fr_q);
          st_q <= SHAcc;
        end
        SHAcc: begin
          if (ix_q >= 6'd32) a_q <= 17'(sig_tab(6'd32));
          else a_q <= 17'(t0_q) + (osel_q ? 17'(ip_q >> 27) : 17'(ip_q >> 19));
          st_q <= osel_q ? SOOut : SOMul;
        end
        SOMul: begin
          oprod_q <= $signed({1'b0, a_q[15:0]}) * ow_rd_q;
          st_q <= SOIx;
        end
        SOIx: begin
          osum_q <= osum_q + 48'(oprod_q);
          accv_q[h_q] <= 1'b0;
          if (h_q == hlast) st_q <= SOSat;
          else begin
            h_q <= h_q + 1'b1;
            st_q <= SHRd;
          end
        end
        SOSat: begin
          // Output argument, Q.28.
          if (osum_q + (48'(ob_q) <<< 16) > 48'(64'sd8 <<< 28)) u_q <= 33'(64'sd16 <<< 28);
          else if (osum_q + (48'(ob_q) <<< 16) < -48'(64'sd8 <<< 28)) u_q <= '0;
          else u_q <= 33'(osum_q + (48'(ob_q) <<< 16) + 48'(64'sd8 <<< 28));
          osel_q <= 1'b1;
          st_q <= SORd;
        end
        SOOut: begin
          out_v_q <= 1'b1;
          out_q.prediction <= a_q[15:0];
          out_q.too_many_inputs <= ovf_q;
          accv_q <= '0; cnt_q <= '0; ovf_q <= 1'b0; h_q <= '0;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // The result register is never overwritten while still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SOOut) |-> (!out_v_q || out_if.ready)) else $error("result overrun");
  // The sample count never exceeds the input limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MaxInputs) else $error("sample count overflow");
  // Words are only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> st_q == SIdle) else $error("accept while busy");
endmodule

@@ bench/mlp_result_checker.sv @@
// Checker: watches the word channels, predicts each result and compares it.
`timescale 1ns / 100ps

module mlp_result_checker
  import mlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_word_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_word_t  out_data_i,
  output int         fail_count_o,
  output int         outstanding_o
);

  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  localparam longint SigmoidTab [33] = '{
    22, 36, 60, 98, 162, 267, 439, 720, 1179, 1921, 3108, 4971, 7812,
    11955, 17625, 24743, 32768, 40793, 47911, 53581, 57724, 60565, 62428,
    63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
  };

  logic signed [15:0] w_in [NumW];
  logic signed [15:0] b_hid [MaxHidden];
  logic signed [15:0] w_out [MaxHidden];
  logic signed [15:0] b_out;
  longint             hid_acc [MaxHidden];
  int                 n_taken;
  bit                 overflow;
  logic [2:0]         hid_cfg;
  out_word_t          predictions_q [$];
  int                 fails;

  assign fail_count_o  = fails;
  assign outstanding_o = predictions_q.size();

  // Table sigmoid with linear interpolation; x carries fb fraction bits.
  function automatic logic [15:0] sigmoid_q16(longint x, int fb);
    longint lim;
    longint unsigned u, idx, frac;
    lim = longint'(8) <<< fb;
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    u    = x + lim;
    idx  = u >> (fb - 1);
    frac = u & ((64'd1 << (fb - 1)) - 1);
    if (idx >= 32) return 16'(SigmoidTab[32]);
    return 16'(SigmoidTab[idx] +
               (((SigmoidTab[idx + 1] - SigmoidTab[idx]) * frac) >> (fb - 1)));
  endfunction

  function automatic out_word_t forward_pass();
    out_word_t r;
    longint    osum;
    int        nh;
    nh = hid_cfg;
    if (nh < 1) nh = 1;
    if (nh > MaxHidden) nh = MaxHidden;
    osum = longint'(b_out) * 65536;
    for (int h = 0; h < nh; h++) begin
      osum += longint'(sigmoid_q16(hid_acc[h] + longint'(b_hid[h]) * 256, 20))
              * longint'(w_out[h]);
    end
    r.prediction      = sigmoid_q16(osum, 28);
    r.too_many_inputs = overflow;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint s;
    out_word_t exp_w;
    if (!rst_ni) begin
      hid_cfg  = 3'd3;
      hid_acc  = '{default: 0};
      n_taken  = 0;
      overflow = 1'b0;
      fails    = 0;
      predictions_q.delete();
    end else begin
      if (cfg_we_i) hid_cfg = cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OpWrite) begin
          if (in_data_i.param_index < IdxHb)
            w_in[in_data_i.param_index[ParW-1:0]] = in_data_i.param_value;
          else if (in_data_i.param_index < IdxOw)
            b_hid[HidW'(in_data_i.param_index - IdxHb)] = in_data_i.param_value;
          else if (in_data_i.param_index < IdxOb)
            w_out[HidW'(in_data_i.param_index - IdxOw)] = in_data_i.param_value;
          else if (in_data_i.param_index == IdxOb) b_out = in_data_i.param_value;
        end else begin
          if (n_taken < MaxInputs) begin
            for (int h = 0; h < MaxHidden; h++) begin
              s = hid_acc[h] + longint'(in_data_i.sample_value)
                  * longint'(w_in[ParW'(n_taken * MaxHidden + h)]);
              if (s > AccMax) s = AccMax;
              if (s < AccMin) s = AccMin;
              hid_acc[h] = s;
            end
            n_taken++;
          end else begin
            overflow = 1'b1;
          end
          if (in_data_i.last_sample) begin
            predictions_q = {predictions_q, forward_pass()};
            hid_acc  = '{default: 0};
            n_taken  = 0;
            overflow = 1'b0;
          end
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (predictions_q.size() == 0) begin
          $error("result word with no prediction waiting: prediction=%0d too_many_inputs=%0d",
                 out_data_i.prediction, out_data_i.too_many_inputs);
          fails++;
        end else begin
          exp_w = predictions_q.pop_front();
          if (out_data_i.prediction !== exp_w.prediction) begin
            $error("prediction: expected %0d, got %0d", exp_w.prediction,
                   out_data_i.prediction);
            fails++;
          end
          if (out_data_i.too_many_inputs !== exp_w.too_many_inputs) begin
            $error("too_many_inputs: expected %0d, got %0d", exp_w.too_many_inputs,
                   out_data_i.too_many_inputs);
            fails++;
          end
        end
      end
    end
  end

endmodule

@@ bench/mlp_one_hidden_layer_inference_unit_tb.sv @@
// Testbench top: drives parameter and sample words into the perceptron unit and gives the verdict.
`timescale 1ns / 100ps

module mlp_one_hidden_layer_inference_unit_tb;
  import mlp_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  int         fail_count;
  int         outstanding;
  bit         quiet;

  mlp_in_if  in_if ();
  mlp_out_if out_if ();

  mlp_one_hidden_layer_inference_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // The checker only observes; it never drives a channel.
  mlp_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one word from a falling edge and returns at the falling edge after
  // it has been taken. An idle burst, when one falls, lowers valid first.
  task automatic put_word(in_word_t w);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_param(logic [4:0] idx, logic signed [15:0] val, logic last);
    in_word_t w;
    w.opcode       = OpWrite;
    w.param_index  = idx;
    w.param_value  = val;
    w.sample_value = 24'($urandom());
    w.last_sample  = last;
    put_word(w);
  endtask

  task automatic put_sample(logic signed [23:0] val, logic last);
    in_word_t w;
    w.opcode       = OpSample;
    w.param_index  = 5'($urandom());
    w.param_value  = 16'($urandom());
    w.sample_value = val;
    w.last_sample  = last;
    put_word(w);
  endtask

  // Samples are mostly kept within the sigmoid's working range so that the
  // interpolation is exercised, with a share of full-scale values for saturation.
  function automatic logic signed [23:0] pick_sample();
    if ($urandom_range(0, 3) == 0) return 24'($urandom());
    return 24'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic logic signed [15:0] pick_param();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // A vector of samples; now and then it runs past the input limit and now
  // and then a parameter write lands in the middle of it.
  task automatic play_vector();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, MaxInputs);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        write_param(5'($urandom()), pick_param(), 1'($urandom()));
      put_sample(pick_sample(), i == n - 1);
    end
  endtask

  // The register may only change while the unit is idle: every prediction
  // must have come out, and a margin follows for the per-neuron sigmoid walk
  // of a last sample.
  task automatic set_hidden(logic [2:0] n);
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // The receiver stalls in random bursts, and once holds off for a long
  // stretch so that the unit fills up and back-pressures its input.
  initial begin
    int cyc;
    int stall;
    cyc   = 0;
    stall = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 3000) stall = 400;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        stall = $urandom_range(1, 19) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("** mlp_one_hidden_layer_inference_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [2:0] settings [6];
    settings = '{3'd3, 3'd1, 3'd4, 3'd0, 3'd7, 3'd2};
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 3'd0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every parameter entry is written before any sample reads it, with both
    // extremes of the word placed among the first-input weights.
    for (int i = 0; i <= IdxOb; i++) begin
      if (i == 0) write_param(5'(i), 16'sh8000, 1'b0);
      else if (i == 1) write_param(5'(i), 16'sh7fff, 1'b0);
      else write_param(5'(i), pick_param(), 1'b0);
    end
    // Writes beyond the store are ignored; a write marked last gives no result.
    write_param(5'd25, 16'sh7fff, 1'b0);
    write_param(5'd31, 16'sh8000, 1'b1);
    // Full-scale samples of both signs, then a vector that exceeds the input limit.
    put_sample(24'sh7fffff, 1'b1);
    put_sample(24'sh800000, 1'b0);
    put_sample(24'sh000000, 1'b1);
    for (int i = 0; i < 6; i++) put_sample(pick_sample(), i == 5);

    foreach (settings[p]) begin
      set_hidden(settings[p]);
      if (p == 5) quiet = 1'b1;
      for (int k = 0; k < 230;) begin
        if ($urandom_range(0, 3) == 0) begin
          write_param(5'($urandom()), pick_param(), 1'($urandom()));
          k++;
        end else begin
          play_vector();
          k += 3;
        end
      end
    end

    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** mlp_one_hidden_layer_inference_unit: PASSED **");
    end else begin
      $display("** mlp_one_hidden_layer_inference_unit: FAILED **");
    end
    $finish;
  end

endmodule
